>>> design/bpfl_pkg.sv
// ----------------------------------------------------------------------------
// bpfl_pkg
// Shared types for the buffer pool free list manager: sequencer states and
// request status codes.
// ----------------------------------------------------------------------------
package bpfl_pkg;

    typedef enum logic [3:0] {
        S_FILL,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_WR,
        S_FREE_CHK,
        S_FREE_RANGE,
        S_FREE_DIV,
        S_FREE_WR,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_NULL    = 3'd2,
        ST_OUTSIDE = 3'd3,
        ST_DOUBLE  = 3'd4
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

>>> design/buffer_pool_free_list_manager.sv
// Allocate reads the head's link and then pops it; an empty pool skips the pop.
// Free checks for null, below and above the pool, then runs the two-stage reciprocal
// multiply that maps the address to a buffer index, then reads its link to push it or
// refuse it as a double free. One request at a time; a stalled result holds the
// next request off.
// Reset: the link memory is filled, no request accepted meanwhile.
// ----------------------------------------------------------------------------
// buffer_pool_free_list_manager
// Free list allocator for a pool of fixed-size buffers. One link per buffer
// in a link memory with one write and one read port chains the free buffers;
// allocate pops the head, free rounds any address in a buffer down to its header and pushes it.
// ----------------------------------------------------------------------------
module buffer_pool_free_list_manager
    import bpfl_pkg::*;
#(
    parameter int NUM_BUFS  = 64,
    parameter int BUF_BYTES = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: pool base address
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_pool_base,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [31:0] s_buffer_addr,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_header_addr,
    output logic [6:0]  m_free_count
);

    // Index width, link width (0 = null, k+1 = buffer k), divider widths.
    localparam int IW = (NUM_BUFS > 1) ? $clog2(NUM_BUFS) : 1;
    localparam int LW = $clog2(NUM_BUFS + 1);
    localparam int BW = $clog2(BUF_BYTES);
    localparam int DW = IW + BW;
    localparam logic [32:0] SPAN = 33'(NUM_BUFS) * 33'(BUF_BYTES);

    state_t state_reg, state_next;

    logic [IW-1:0] fill_cnt_reg, fill_cnt_next;
    logic [LW-1:0] head_reg, head_next;
    logic [LW-1:0] free_total_reg, free_total_next;
    logic [31:0]   pool_base_reg;
    logic [31:0]   addr_reg, addr_next;
    logic [31:0]   off_reg, off_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [31:0]   prod_reg, prod_next;
    status_t       res_status_reg, res_status_next;
    logic [31:0]   res_header_reg, res_header_next;

    logic          m_valid_reg, m_valid_next;
    status_t       m_status_reg, m_status_next;
    logic [31:0]   m_header_reg, m_header_next;
    logic [6:0]    m_count_reg, m_count_next;

    // link memory
    logic [LW-1:0] link_mem [NUM_BUFS];
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [LW-1:0] mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;
    logic [LW-1:0] link_rd_reg;

    // divider
    logic          div_start;
    logic          div_done;
    logic [IW-1:0] div_quotient;
    logic [DW-1:0] div_remainder;

    // request checks
    logic          alloc_err;
    logic          free_null;
    logic          free_below;
    logic          free_above;
    logic          out_free;
    logic [LW-1:0] head_dec;
    logic [IW-1:0] head_idx;

    assign head_dec   = head_reg - LW'(1);
    assign head_idx   = head_dec[IW-1:0];
    assign alloc_err  = (free_total_reg == '0) || (head_reg == '0) ||
                        (head_reg > LW'(NUM_BUFS));
    assign free_null  = (addr_reg == '0);
    assign free_below = (addr_reg < pool_base_reg);
    assign free_above = ({1'b0, off_reg} >= SPAN);
    assign out_free   = !m_valid_reg || m_ready;

    bpfl_div #(
        .QW      (IW),
        .DW      (DW),
        .DIVISOR (BUF_BYTES)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (off_reg[DW-1:0]),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_FILL: begin
                if (fill_cnt_reg == IW'(NUM_BUFS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_opcode == OP_FREE) ? S_FREE_CHK : S_ALLOC_RD;
                end
            end
            S_ALLOC_RD: begin
                state_next = alloc_err ? S_DONE : S_ALLOC_WR;
            end
            S_ALLOC_WR: begin
                state_next = S_DONE;
            end
            S_FREE_CHK: begin
                state_next = (free_null || free_below) ? S_DONE : S_FREE_RANGE;
            end
            S_FREE_RANGE: begin
                state_next = free_above ? S_DONE : S_FREE_DIV;
            end
            S_FREE_DIV: begin
                if (div_done) begin
                    state_next = S_FREE_WR;
                end
            end
            S_FREE_WR: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath and memory control
    // ------------------------------------------------------------------
    always_comb begin
        fill_cnt_next   = fill_cnt_reg;
        head_next       = head_reg;
        free_total_next = free_total_reg;
        addr_next       = addr_reg;
        off_next        = off_reg;
        idx_next        = idx_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_header_next = res_header_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_header_next   = m_header_reg;
        m_count_next    = m_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = idx_reg;
        div_start       = 1'b0;

        // drop the result once the consumer takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_FILL: begin
                // chain entry i to buffer i+1, last entry null
                mem_we    = 1'b1;
                mem_waddr = fill_cnt_reg;
                if (fill_cnt_reg == IW'(NUM_BUFS - 1)) begin
                    mem_wdata = '0;
                end else begin
                    mem_wdata = LW'(fill_cnt_reg) + LW'(2);
                end
                fill_cnt_next = fill_cnt_reg + IW'(1);
            end
            S_IDLE: begin
                addr_next = s_buffer_addr;
            end
            S_ALLOC_RD: begin
                if (alloc_err) begin
                    res_status_next = ST_EMPTY;
                    res_header_next = '0;
                end else begin
                    // fetch the head's link, start the header offset
                    mem_re    = 1'b1;
                    mem_raddr = head_idx;
                    idx_next  = head_idx;
                    prod_next = 32'(32'(head_idx) * 32'(BUF_BYTES));
                end
            end
            S_ALLOC_WR: begin
                // pop: advance head, clear the taken buffer's link
                head_next       = link_rd_reg;
                mem_we          = 1'b1;
                mem_waddr       = idx_reg;
                mem_wdata       = '0;
                free_total_next = free_total_reg - LW'(1);
                res_status_next = ST_OK;
                res_header_next = pool_base_reg + prod_reg;
            end
            S_FREE_CHK: begin
                off_next = addr_reg - pool_base_reg;
                if (free_null) begin
                    res_status_next = ST_NULL;
                    res_header_next = '0;
                end else if (free_below) begin
                    res_status_next = ST_OUTSIDE;
                    res_header_next = '0;
                end
            end
            S_FREE_RANGE: begin
                if (free_above) begin
                    res_status_next = ST_OUTSIDE;
                    res_header_next = '0;
                end else begin
                    div_start = 1'b1;
                end
            end
            S_FREE_DIV: begin
                if (div_done) begin
                    mem_re    = 1'b1;
                    mem_raddr = div_quotient;
                    idx_next  = div_quotient;
                end
            end
            S_FREE_WR: begin
                if (link_rd_reg != '0) begin
                    res_status_next = ST_DOUBLE;
                    res_header_next = '0;
                end else begin
                    // push: link to old head, buffer becomes head
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg;
                    mem_wdata = head_reg;
                    head_next = LW'(idx_reg) + LW'(1);
                    if (free_total_reg < LW'(NUM_BUFS)) begin
                        free_total_next = free_total_reg + LW'(1);
                    end
                    res_status_next = ST_OK;
                    res_header_next = addr_reg - 32'(div_remainder);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_header_next = res_header_reg;
                    m_count_next  = 7'(free_total_reg);
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_FILL;
            fill_cnt_reg   <= '0;
            head_reg       <= LW'(1);
            free_total_reg <= LW'(NUM_BUFS);
            pool_base_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_cnt_reg   <= fill_cnt_next;
            head_reg       <= head_next;
            free_total_reg <= free_total_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid) begin
                pool_base_reg <= cfg_pool_base;
            end
        end
        addr_reg       <= addr_next;
        off_reg        <= off_next;
        idx_reg        <= idx_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_header_reg <= res_header_next;
        m_status_reg   <= m_status_next;
        m_header_reg   <= m_header_next;
        m_count_reg    <= m_count_next;
    end

    // link memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            link_rd_reg <= link_mem[mem_raddr];
        end
    end

    assign cfg_ready     = 1'b1;
    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_header_addr = m_header_reg;
    assign m_free_count  = m_count_reg;

endmodule

>>> design/bpfl_div.sv
// ----------------------------------------------------------------------------
// bpfl_div
// Division by the constant buffer size through a reciprocal multiply: the
// product is registered first, then quotient and remainder from it. Exact
// for any dividend below 2**DW.
// ----------------------------------------------------------------------------
module bpfl_div
    import bpfl_pkg::*;
#(
    parameter int QW      = 6,
    parameter int DW      = 17,
    parameter int DIVISOR = 2048
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    output logic          done,
    output logic [QW-1:0] quotient,
    output logic [DW-1:0] remainder
);

    // ceil(2**SH / DIVISOR) keeps floor(x * RECIP / 2**SH) exact for x < 2**DW
    localparam int LG = $clog2(DIVISOR);
    localparam int SH = DW + LG;
    localparam int MW = DW + 1;
    localparam int PW = DW + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [DW-1:0] dvd_reg;
    logic [PW-1:0] prod_reg, prod_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic          stage_reg;
    logic          done_reg;

    // DW by DW+1 bit product with a constant, then a small constant multiply
    always_comb begin
        prod_next = PW'(dividend) * PW'(RECIP);
        quo_next  = prod_reg[SH +: QW];
        rem_next  = dvd_reg - DW'(quo_next) * DW'(DIVISOR);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            stage_reg <= start;
            done_reg  <= stage_reg;
        end
        if (start) begin
            dvd_reg  <= dividend;
            prod_reg <= prod_next;
        end
        // hold quotient and remainder until the next start
        if (stage_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> tb/buffer_pool_free_list_manager_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_pool_free_list_manager_test
// Self-checking bench for the buffer pool free list manager. Requests are fed
// from a queue by a clocked driver. Each accepted request is run through a
// behavioral model of the free list, and the monitor compares every result
// with the oldest prediction. Both channels idle and stall at random. The
// pool base moves between phases, across its extremes.
// ----------------------------------------------------------------------------
module buffer_pool_free_list_manager_test
    import bpfl_pkg::*;
();

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 9;
    localparam int NUM_BUFS     = 64;
    localparam int BUF_BYTES    = 2048;
    localparam int POOL_BYTES   = NUM_BUFS * BUF_BYTES;
    localparam logic [32:0] POOL_SPAN = 33'(POOL_BYTES);
    // settle time after the last result, with margin
    localparam int SETTLE_CYCLES = 24;
    localparam int STUCK_LIMIT   = 3000;
    localparam int NUM_PHASES    = 6;
    localparam int RANDOM_PER_PHASE = 150;
    // two copies of the free list model: one steers stimulus, one scores
    localparam int MDL_PLAN  = 0;
    localparam int MDL_SCORE = 1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] addr;
    } pool_request_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] hdr;
        logic [6:0]  count;
    } pool_result_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_pool_base = 32'h0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic        s_opcode      = OP_ALLOC;
    logic [31:0] s_buffer_addr = 32'h0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_header_addr;
    logic [6:0]  m_free_count;

    // free list model state, one slot per copy
    logic [31:0] model_base  [2];
    logic [6:0]  model_link  [2][NUM_BUFS];
    logic [6:0]  model_head  [2];
    logic [6:0]  model_total [2];

    pool_request_t request_q[$];
    pool_result_t  grant_q[$];

    int  items_issued  = 0;
    int  results_done  = 0;
    int  mismatches    = 0;
    int  stuck_cycles  = 0;
    int  req_gap       = 0;
    int  rsp_stall     = 0;
    bit  s_quiet       = 1'b0;
    bit  m_quiet       = 1'b0;
    bit  drain_mode    = 1'b1;
    int  refill_goal   = 48;

    buffer_pool_free_list_manager #(
        .NUM_BUFS  (NUM_BUFS),
        .BUF_BYTES (BUF_BYTES)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_pool_base (cfg_pool_base),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_buffer_addr (s_buffer_addr),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_header_addr (m_header_addr),
        .m_free_count  (m_free_count)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Load the after-reset picture: every buffer chained in index order.
    task automatic reset_pool_model(input int m);
        model_base[m]  = 32'h0;
        for (int i = 0; i < NUM_BUFS; i++) begin
            model_link[m][i] = (i + 1 < NUM_BUFS) ? 7'(i + 2) : 7'd0;
        end
        model_head[m]  = 7'd1;
        model_total[m] = 7'(NUM_BUFS);
    endtask

    // Apply one request to model copy m and produce its result.
    // Links and the head use 0 for null and k+1 for buffer k.
    task automatic pool_step(input int m, input logic opcode, input logic [31:0] addr,
                             output pool_result_t r);
        logic [32:0] offset;
        int unsigned idx;
        r.status = ST_OK;
        r.hdr    = 32'h0;
        if (opcode == OP_ALLOC) begin
            // a null or out-of-range head counts as empty, like a zero total
            if (model_total[m] == 0 || model_head[m] == 0 || model_head[m] > NUM_BUFS) begin
                r.status = ST_EMPTY;
            end else begin
                idx = model_head[m] - 1;
                model_head[m]       = model_link[m][idx];
                model_link[m][idx]  = 7'd0;
                model_total[m]      = model_total[m] - 7'd1;
                r.hdr               = model_base[m] + idx * BUF_BYTES;
            end
        end else begin
            offset = {1'b0, addr} - {1'b0, model_base[m]};
            // null check wins even when the pool itself starts at zero
            if (addr == 32'h0) begin
                r.status = ST_NULL;
            end else if (addr < model_base[m] || offset >= POOL_SPAN) begin
                r.status = ST_OUTSIDE;
            end else begin
                idx = offset / BUF_BYTES;
                if (model_link[m][idx] != 0) begin
                    r.status = ST_DOUBLE;
                end else begin
                    // the list tail also has a null link, so it goes back on again
                    model_link[m][idx] = model_head[m];
                    model_head[m]      = 7'(idx + 1);
                    if (model_total[m] < NUM_BUFS) begin
                        model_total[m] = model_total[m] + 7'd1;
                    end
                    r.hdr = model_base[m] + idx * BUF_BYTES;
                end
            end
        end
        r.count = model_total[m];
    endtask

    // Queue one request and advance the planning copy past it.
    task automatic queue_request(input logic opcode, input logic [31:0] addr,
                                 output pool_result_t planned);
        pool_request_t item;
        item.opcode = opcode;
        item.addr   = addr;
        pool_step(MDL_PLAN, opcode, addr, planned);
        request_q.push_back(item);
        items_issued++;
    endtask

    // Pick a random address inside a buffer whose link is null (taken, or the
    // list tail) and whose header is reachable without wrapping.
    task automatic pick_taken_buffer(output bit found, output logic [31:0] addr);
        logic [32:0] a;
        int          hits;
        int          pick;
        hits  = 0;
        found = 1'b0;
        addr  = 32'h0;
        for (int i = 0; i < NUM_BUFS; i++) begin
            if (model_link[MDL_PLAN][i] == 0 &&
                {1'b0, model_base[MDL_PLAN]} + i * BUF_BYTES < 33'h1_0000_0000) begin
                hits++;
            end
        end
        if (hits != 0) begin
            pick = $urandom_range(0, hits - 1);
            for (int i = 0; i < NUM_BUFS; i++) begin
                if (model_link[MDL_PLAN][i] == 0 &&
                    {1'b0, model_base[MDL_PLAN]} + i * BUF_BYTES < 33'h1_0000_0000) begin
                    if (pick == 0 && !found) begin
                        a = {1'b0, model_base[MDL_PLAN]} + i * BUF_BYTES
                            + $urandom_range(0, BUF_BYTES - 1);
                        // clamp into the last buffer when the pool runs off the top
                        if (a[32]) begin
                            a = 33'h0_FFFF_FFFF;
                        end
                        if (a[31:0] == 32'h0) begin
                            a = 33'h1;
                        end
                        addr  = a[31:0];
                        found = 1'b1;
                    end
                    pick--;
                end
            end
        end
    endtask

    // Free addresses off the well-formed path: edges of the pool, null, noise.
    function automatic logic [31:0] noise_addr();
        logic [31:0] b;
        b = model_base[MDL_PLAN];
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return b - 32'd1;
            2:       return b + POOL_BYTES;
            3:       return b + POOL_BYTES - 1;
            4:       return 32'hFFFF_FFFF;
            5:       return b + $urandom_range(0, POOL_BYTES - 1);
            6:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Short walk through the corners with the pool at address zero.
    task automatic queue_directed();
        pool_result_t r;
        queue_request(OP_ALLOC, 32'hFFFF_FFFF, r);  // pop buffer 0, address ignored
        queue_request(OP_FREE,  32'h0000_0000, r);  // null, though buffer 0 sits there
        queue_request(OP_FREE,  32'h0000_07FF, r);  // last byte of buffer 0: push back
        queue_request(OP_FREE,  32'h0000_0001, r);  // buffer 0 again: double free
        queue_request(OP_FREE,  32'h0001_F800, r);  // list tail freed while free
        queue_request(OP_FREE,  32'h0002_0000, r);  // first byte past the pool
        queue_request(OP_FREE,  32'hFFFF_FFFF, r);  // top of the address space
        queue_request(OP_FREE,  32'h0001_FFFF, r);  // last byte of the pool
        queue_request(OP_FREE,  32'h0001_0A5A, r);  // mid-pool, still free
        queue_request(OP_ALLOC, 32'h0000_0000, r);
        queue_request(OP_ALLOC, 32'h5555_5555, r);
        queue_request(OP_ALLOC, 32'hAAAA_AAAA, r);
        queue_request(OP_FREE,  32'h0000_0800, r);  // header of buffer 1
        queue_request(OP_FREE,  32'h0000_0FFF, r);  // same buffer, last byte
        queue_request(OP_ALLOC, 32'h8000_0000, r);
    endtask

    // Alternate between draining the pool to empty and refilling it; most
    // frees hit taken buffers, the rest probe the edges.
    task automatic queue_random(input int count);
        pool_result_t r;
        logic [31:0]  addr;
        bit           found;
        bit           alloc;
        for (int n = 0; n < count; n++) begin
            alloc = drain_mode ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 20);
            found = 1'b0;
            if (alloc) begin
                queue_request(OP_ALLOC, $urandom, r);
            end else begin
                if ($urandom_range(0, 99) < 75) begin
                    pick_taken_buffer(found, addr);
                end
                if (!found) begin
                    addr = noise_addr();
                end
                queue_request(OP_FREE, addr, r);
            end
            if (drain_mode && r.status == ST_EMPTY && $urandom_range(0, 2) == 0) begin
                drain_mode = 1'b0;
            end else if (!drain_mode &&
                         (model_total[MDL_PLAN] >= refill_goal || $urandom_range(0, 99) == 0)) begin
                drain_mode  = 1'b1;
                refill_goal = $urandom_range(16, NUM_BUFS);
            end
        end
    endtask

    // Write the pool base; only called while the block is idle.
    task automatic write_pool_base(input logic [31:0] value);
        cfg_pool_base <= value;
        cfg_valid     <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        model_base[MDL_PLAN]  = value;
        model_base[MDL_SCORE] = value;
    endtask

    // Request driver: hold a request until it is taken, then idle for a
    // drawn number of cycles before presenting the next one.
    always @(posedge aclk) begin : drive_requests
        pool_result_t  outcome;
        pool_request_t item;
        logic          valid_next;
        if (!aresetn) begin
            s_valid <= 1'b0;
            req_gap  = 0;
        end else begin
            valid_next = s_valid;
            if (s_valid && s_ready) begin
                pool_step(MDL_SCORE, s_opcode, s_buffer_addr, outcome);
                grant_q.push_back(outcome);
                if ($urandom_range(0, 39) == 0) begin
                    s_quiet = !s_quiet;
                end
                req_gap = s_quiet ? 0 : $urandom_range(0, 15);
            end
            if (!s_valid || s_ready) begin
                valid_next = 1'b0;
                if (req_gap != 0) begin
                    req_gap--;
                end else if (request_q.size() != 0) begin
                    item           = request_q.pop_front();
                    s_opcode      <= item.opcode;
                    s_buffer_addr <= item.addr;
                    valid_next     = 1'b1;
                end
            end
            s_valid <= valid_next;
        end
    end

    // Result monitor: score each result against the oldest prediction, then
    // stall the channel for a drawn number of cycles.
    always @(posedge aclk) begin : check_results
        pool_result_t want;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rsp_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_done++;
                if (grant_q.size() == 0) begin
                    $display("%0t: unexpected result: status %0d header %h count %0d",
                             $time, m_status, m_header_addr, m_free_count);
                    mismatches++;
                end else begin
                    want = grant_q.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, m_status);
                        mismatches++;
                    end
                    if (m_header_addr !== want.hdr) begin
                        $display("%0t: header_addr expected %h, got %h",
                                 $time, want.hdr, m_header_addr);
                        mismatches++;
                    end
                    if (m_free_count !== want.count) begin
                        $display("%0t: free_count expected %0d, got %0d",
                                 $time, want.count, m_free_count);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 39) == 0) begin
                    m_quiet = !m_quiet;
                end
                rsp_stall = m_quiet ? 0 : $urandom_range(0, 15);
            end else if (rsp_stall != 0) begin
                rsp_stall--;
            end
            m_ready <= (rsp_stall == 0);
        end
    end

    // Watchdog: drop the run when no channel has moved for too long.
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Sequence: reset, then phases of requests with a new pool base in each.
    // Between phases wait until every result is back and the block is quiet.
    initial begin : run_phases
        logic [31:0] base;
        reset_pool_model(MDL_PLAN);
        reset_pool_model(MDL_SCORE);
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            while (results_done != items_issued) @(posedge aclk);
            if (ph != 0) begin
                repeat (SETTLE_CYCLES) @(posedge aclk);
            end
            case (ph)
                1:       base = $urandom;
                2:       base = 32'hFFFF_0000;   // pool runs off the top of memory
                3:       base = 32'hFFFF_FFFF;   // only one byte of the pool is addressable
                4:       base = $urandom & 32'hFFFF_F800;
                default: base = 32'h0;
            endcase
            write_pool_base(base);
            if (ph == 0) begin
                queue_directed();
            end
            queue_random(RANDOM_PER_PHASE);
        end
        while (results_done != items_issued) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && grant_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> files.f
design/bpfl_pkg.sv
design/bpfl_div.sv
design/buffer_pool_free_list_manager.sv
tb/buffer_pool_free_list_manager_test.sv
